@@ hw/rtl/rgb_text_command_parser_defines.svh @@
// Assertion macros shared by the RGB text command parser RTL.
`ifndef RGB_TEXT_COMMAND_PARSER_DEFINES_SVH
`define RGB_TEXT_COMMAND_PARSER_DEFINES_SVH

// Same-cycle implication, checked on clk outside reset.
`define RGBTP_ASSERT_NOW(label, cond, expect_now) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expect_now)) \
        else $error("rgbtp assertion failed");

// Next-cycle implication, checked on clk outside reset.
`define RGBTP_ASSERT_NEXT(label, cond, expect_next) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect_next)) \
        else $error("rgbtp assertion failed");

`endif

@@ hw/rtl/rgbtp_pkg.sv @@
// Package: character codes, command and status codes, parser state types.
`default_nettype none

package rgbtp_pkg;

    // Character codes
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_VT    = 8'd11;
    localparam logic [7:0] CHAR_FF    = 8'd12;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_COMMA = 8'd44;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_QUERY = 8'd63;
    localparam logic [7:0] CHAR_UP_B  = 8'd66;
    localparam logic [7:0] CHAR_UP_C  = 8'd67;
    localparam logic [7:0] CHAR_UP_G  = 8'd71;
    localparam logic [7:0] CHAR_UP_H  = 8'd72;
    localparam logic [7:0] CHAR_UP_R  = 8'd82;
    localparam logic [7:0] CHAR_LO_A  = 8'd97;
    localparam logic [7:0] CHAR_LO_Z  = 8'd122;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    // Magnitude saturation point and last field index of a C line
    localparam logic [8:0] MAG_SAT    = 9'd256;
    localparam logic [1:0] LAST_FIELD = 2'd2;

    // Result status codes
    localparam logic [3:0] ST_RED     = 4'd0;
    localparam logic [3:0] ST_GREEN   = 4'd1;
    localparam logic [3:0] ST_BLUE    = 4'd2;
    localparam logic [3:0] ST_ALL     = 4'd3;
    localparam logic [3:0] ST_HELP    = 4'd4;
    localparam logic [3:0] ST_SHOW    = 4'd5;
    localparam logic [3:0] ST_RANGE   = 4'd6;
    localparam logic [3:0] ST_FORMAT  = 4'd7;
    localparam logic [3:0] ST_UNKNOWN = 4'd8;

    typedef enum logic [2:0] {
        CMD_R       = 3'd0,
        CMD_G       = 3'd1,
        CMD_B       = 3'd2,
        CMD_C       = 3'd3,
        CMD_H       = 3'd4,
        CMD_SHOW    = 3'd5,
        CMD_UNKNOWN = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    // Per-line parse state
    typedef struct packed {
        logic       line_started;
        cmd_t       cmd;
        logic [1:0] field_number;
        phase_t     phase;
        logic       negative;
        logic [8:0] magnitude;
        logic       first_nonempty;
        logic [7:0] pending_red;
        logic [7:0] pending_green;
        logic       pending_ok;
    } line_state_t;

    localparam line_state_t LINE_CLEAR = '{
        line_started:   1'b0,
        cmd:            CMD_R,
        field_number:   2'd0,
        phase:          PH_SKIP,
        negative:       1'b0,
        magnitude:      9'd0,
        first_nonempty: 1'b0,
        pending_red:    8'd0,
        pending_green:  8'd0,
        pending_ok:     1'b1
    };

    // One result as produced by the parser
    typedef struct packed {
        logic       fire;
        logic [3:0] status;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } result_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic cmd_t decode_command(input logic [7:0] c);
        logic [7:0] u;
        cmd_t       k;
        u = ((c >= CHAR_LO_A) && (c <= CHAR_LO_Z)) ? (c - CASE_OFFSET) : c;
        case (u)
            CHAR_UP_R:  k = CMD_R;
            CHAR_UP_G:  k = CMD_G;
            CHAR_UP_B:  k = CMD_B;
            CHAR_UP_C:  k = CMD_C;
            CHAR_UP_H:  k = CMD_H;
            CHAR_QUERY: k = CMD_SHOW;
            default:    k = CMD_UNKNOWN;
        endcase
        return k;
    endfunction

    // Value 0..255, with "-0" allowed
    function automatic logic field_ok(input logic neg, input logic [8:0] mag);
        return !mag[8] && !(neg && (mag != 9'd0));
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rgbtp_parser.sv @@
// Line parser: per-line state, color registers and the result of a line end.
`default_nettype none
`include "rgb_text_command_parser_defines.svh"

module rgbtp_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        char_in,
    output rgbtp_pkg::result_t     res
);
    import rgbtp_pkg::*;

    line_state_t st_reg, st_next;
    logic [7:0]  red_reg, red_next;
    logic [7:0]  green_reg, green_next;
    logic [7:0]  blue_reg, blue_next;

    logic        line_end;
    logic        digit;
    logic [3:0]  digit_val;
    logic [11:0] mag_x10;
    logic        cur_ok;

    assign line_end  = (char_in == CHAR_LF) || (char_in == CHAR_CR);
    assign digit     = is_digit(char_in);
    assign digit_val = 4'(char_in - CHAR_ZERO);
    assign cur_ok    = field_ok(st_reg.negative, st_reg.magnitude);
    // m*10 + d, at most 2569
    assign mag_x10   = ({3'b0, st_reg.magnitude} << 3) + ({3'b0, st_reg.magnitude} << 1)
                     + {8'b0, digit_val};

    // Next state and result for the byte on char_in
    always_comb
    begin
        st_next    = st_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        res.fire   = 1'b0;
        res.status = ST_UNKNOWN;

        if (line_end)
        begin
            if (st_reg.line_started)
            begin
                res.fire = 1'b1;
                case (st_reg.cmd)
                    CMD_R:
                    begin
                        if (cur_ok)
                        begin
                            red_next   = st_reg.magnitude[7:0];
                            res.status = ST_RED;
                        end
                        else
                            res.status = ST_RANGE;
                    end
                    CMD_G:
                    begin
                        if (cur_ok)
                        begin
                            green_next = st_reg.magnitude[7:0];
                            res.status = ST_GREEN;
                        end
                        else
                            res.status = ST_RANGE;
                    end
                    CMD_B:
                    begin
                        if (cur_ok)
                        begin
                            blue_next  = st_reg.magnitude[7:0];
                            res.status = ST_BLUE;
                        end
                        else
                            res.status = ST_RANGE;
                    end
                    CMD_C:
                    begin
                        if ((st_reg.field_number != LAST_FIELD) || !st_reg.first_nonempty)
                            res.status = ST_FORMAT;
                        else if (!cur_ok || !st_reg.pending_ok)
                            res.status = ST_RANGE;
                        else
                        begin
                            red_next   = st_reg.pending_red;
                            green_next = st_reg.pending_green;
                            blue_next  = st_reg.magnitude[7:0];
                            res.status = ST_ALL;
                        end
                    end
                    CMD_H:    res.status = ST_HELP;
                    CMD_SHOW: res.status = ST_SHOW;
                    default:  res.status = ST_UNKNOWN;
                endcase
            end
            st_next = LINE_CLEAR;
        end
        else if (!st_reg.line_started)
        begin
            // Command byte opens the line
            if (!is_blank(char_in))
            begin
                st_next              = LINE_CLEAR;
                st_next.line_started = 1'b1;
                st_next.cmd          = decode_command(char_in);
            end
        end
        else if ((st_reg.cmd == CMD_C) && (st_reg.field_number < LAST_FIELD)
                 && (char_in == CHAR_COMMA))
        begin
            // Field separator of a C line
            if (cur_ok)
            begin
                if (st_reg.field_number == 2'd0)
                    st_next.pending_red = st_reg.magnitude[7:0];
                else
                    st_next.pending_green = st_reg.magnitude[7:0];
            end
            else
                st_next.pending_ok = 1'b0;
            st_next.field_number = st_reg.field_number + 2'd1;
            st_next.phase        = PH_SKIP;
            st_next.negative     = 1'b0;
            st_next.magnitude    = 9'd0;
        end
        else
        begin
            if ((st_reg.cmd == CMD_C) && (st_reg.field_number == 2'd0))
                st_next.first_nonempty = 1'b1;
            // Number scanner
            case (st_reg.phase)
                PH_SKIP:
                begin
                    if (is_blank(char_in))
                        st_next.phase = PH_SKIP;
                    else if ((char_in == CHAR_PLUS) || (char_in == CHAR_MINUS))
                    begin
                        st_next.negative = (char_in == CHAR_MINUS);
                        st_next.phase    = PH_SIGN;
                    end
                    else if (digit)
                    begin
                        st_next.magnitude = {5'b0, digit_val};
                        st_next.phase     = PH_DIGITS;
                    end
                    else
                        st_next.phase = PH_DONE;
                end
                PH_SIGN:
                begin
                    if (digit)
                    begin
                        st_next.magnitude = {5'b0, digit_val};
                        st_next.phase     = PH_DIGITS;
                    end
                    else
                        st_next.phase = PH_DONE;
                end
                PH_DIGITS:
                begin
                    if (digit)
                        st_next.magnitude = (mag_x10 > {3'b0, MAG_SAT}) ? MAG_SAT
                                                                          : mag_x10[8:0];
                    else
                        st_next.phase = PH_DONE;
                end
                default: st_next.phase = st_reg.phase;
            endcase
        end

        res.red   = red_next;
        res.green = green_next;
        res.blue  = blue_next;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= LINE_CLEAR;
            red_reg   <= 8'd0;
            green_reg <= 8'd0;
            blue_reg  <= 8'd0;
        end
        else if (step)
        begin
            st_reg    <= st_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    // Colors move only on a transfer of a line end
    `RGBTP_ASSERT_NEXT(a_color_hold, !(step && line_end),
        $stable(red_reg) && $stable(green_reg) && $stable(blue_reg))
    // A line end always closes the line
    `RGBTP_ASSERT_NEXT(a_line_closed, step && line_end, !st_reg.line_started)
    // At most two commas are counted
    `RGBTP_ASSERT_NOW(a_field_bound, 1'b1, st_reg.field_number <= LAST_FIELD)

endmodule

`default_nettype wire

@@ hw/rtl/rgb_text_command_parser.sv @@
// Top level: input register, line parser and result register.
`default_nettype none
`include "rgb_text_command_parser_defines.svh"

// RGB text command parser. Takes one received byte per transfer on the input
// channel and gives one result (status plus current red, green and blue) for
// each line that holds a command, when its CR or LF arrives. It takes one byte
// every clock while in_stall is low: a byte is held in the input register, the
// parser updates its line state from it, and a result is written to the result
// register as the line end leaves the input register. in_stall rises only when
// a line end that closes a command line waits in the input register while the
// result register still holds a result that has not been taken; other bytes
// keep flowing meanwhile.
module rgb_text_command_parser (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [3:0]      status,
    output logic [7:0]      red,
    output logic [7:0]      green,
    output logic [7:0]      blue
);
    import rgbtp_pkg::*;

    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       out_valid_reg;
    logic [3:0] status_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;

    result_t    res;
    logic       advance;
    logic       in_take;
    logic       out_take;
    logic       out_free;

    rgbtp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .char_in (byte_reg),
        .res     (res)
    );

    // Handshake control
    assign out_take = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && (!res.fire || out_free);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            byte_reg <= rx_byte;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && res.fire)
            out_valid_reg <= 1'b1;
        else if (out_take)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.fire)
        begin
            status_reg <= res.status;
            red_reg    <= res.red;
            green_reg  <= res.green;
            blue_reg   <= res.blue;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

    // Input is held back only by an untaken result
    `RGBTP_ASSERT_NOW(a_stall_cause, in_stall, out_valid_reg && out_stall && res.fire)
    // Status codes stay within the defined set
    `RGBTP_ASSERT_NOW(a_status_range, out_valid_reg, status_reg <= ST_UNKNOWN)
    // A result never overwrites one that is still waiting
    `RGBTP_ASSERT_NEXT(a_no_overwrite, out_valid_reg && out_stall,
        out_valid_reg && $stable(status_reg) && $stable(red_reg))

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the RGB text command parser.
`timescale 1ns / 1ps

module testbench;
    import rgbtp_pkg::*;

    localparam int RANDOM_BYTES = 570;
    localparam int CALM_AFTER   = 470;
    localparam int HOLD_AT      = 250;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_LIMIT  = 2000;

    typedef struct packed {
        logic [3:0] status;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } line_report_t;

    typedef enum logic [1:0] {
        ROW_MODEL,
        ROW_TYPED,
        ROW_QUIET
    } row_kind_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall;
    logic [3:0] status;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    rgb_text_command_parser uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    // Reports still owed by the parser, oldest first
    line_report_t expected_reports[$];
    int           errors;
    int           bytes_sent;
    bit           idle_on;
    bit           long_hold_req;
    int           stall_left;

    // Directed lines and the report typed in for them
    string        row_text[$];
    row_kind_t    row_kind[$];
    line_report_t row_report[$];

    // Bytes of the random line being built
    logic [7:0]   line_buf[$];

    // Parser mirror: per-line state and current color
    bit           ln_started;
    cmd_t         ln_cmd;
    logic [1:0]   ln_field;
    phase_t       ln_phase;
    bit           ln_neg;
    logic [8:0]   ln_mag;
    bit           ln_first_seen;
    logic [7:0]   ln_pend_red;
    logic [7:0]   ln_pend_green;
    bit           ln_pend_ok;
    logic [7:0]   cur_red;
    logic [7:0]   cur_green;
    logic [7:0]   cur_blue;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function void clear_line_state();
        ln_started    = 1'b0;
        ln_cmd        = CMD_R;
        ln_field      = 2'd0;
        ln_phase      = PH_SKIP;
        ln_neg        = 1'b0;
        ln_mag        = 9'd0;
        ln_first_seen = 1'b0;
        ln_pend_red   = 8'd0;
        ln_pend_green = 8'd0;
        ln_pend_ok    = 1'b1;
    endfunction

    function bit blank_char(input logic [7:0] c);
        return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF;
    endfunction

    // 0..255 accepted; a minus sign only with zero
    function bit value_fits();
        return ln_mag <= 9'd255 && !(ln_neg && ln_mag != 9'd0);
    endfunction

    function cmd_t command_of(input logic [7:0] c);
        logic [7:0] u;
        u = (c >= CHAR_LO_A && c <= CHAR_LO_Z) ? c - CASE_OFFSET : c;
        case (u)
            CHAR_UP_R:  return CMD_R;
            CHAR_UP_G:  return CMD_G;
            CHAR_UP_B:  return CMD_B;
            CHAR_UP_C:  return CMD_C;
            CHAR_UP_H:  return CMD_H;
            CHAR_QUERY: return CMD_SHOW;
            default:    return CMD_UNKNOWN;
        endcase
    endfunction

    // Decimal scan: blanks, sign, digits; stops at the first other byte
    function void take_number_char(input logic [7:0] c);
        bit digit;
        int acc;
        digit = c >= CHAR_ZERO && c <= CHAR_NINE;
        case (ln_phase)
            PH_SKIP:
            begin
                if (!blank_char(c))
                begin
                    if (c == CHAR_PLUS || c == CHAR_MINUS)
                    begin
                        ln_neg   = c == CHAR_MINUS;
                        ln_phase = PH_SIGN;
                    end
                    else if (digit)
                    begin
                        ln_mag   = 9'(c - CHAR_ZERO);
                        ln_phase = PH_DIGITS;
                    end
                    else
                        ln_phase = PH_DONE;
                end
            end
            PH_SIGN:
            begin
                if (digit)
                begin
                    ln_mag   = 9'(c - CHAR_ZERO);
                    ln_phase = PH_DIGITS;
                end
                else
                    ln_phase = PH_DONE;
            end
            PH_DIGITS:
            begin
                if (digit)
                begin
                    acc    = int'(ln_mag) * 10 + int'(c - CHAR_ZERO);
                    ln_mag = (acc > int'(MAG_SAT)) ? MAG_SAT : 9'(acc);
                end
                else
                    ln_phase = PH_DONE;
            end
            default: ;
        endcase
    endfunction

    // Advance the mirror by one byte; a line end of a command line gives a report
    function void parse_rx_byte(input logic [7:0] c, output bit fired,
                                output line_report_t rep);
        logic [3:0] st;
        logic [7:0] v;
        bit         ok;
        fired = 1'b0;
        rep   = '0;
        if (c == CHAR_LF || c == CHAR_CR)
        begin
            if (ln_started)
            begin
                v  = ln_mag[7:0];
                ok = value_fits();
                case (ln_cmd)
                    CMD_R:
                    begin
                        st = ok ? ST_RED : ST_RANGE;
                        if (ok) cur_red = v;
                    end
                    CMD_G:
                    begin
                        st = ok ? ST_GREEN : ST_RANGE;
                        if (ok) cur_green = v;
                    end
                    CMD_B:
                    begin
                        st = ok ? ST_BLUE : ST_RANGE;
                        if (ok) cur_blue = v;
                    end
                    CMD_C:
                    begin
                        if (ln_field != LAST_FIELD || !ln_first_seen)
                            st = ST_FORMAT;
                        else if (!ok || !ln_pend_ok)
                            st = ST_RANGE;
                        else
                        begin
                            cur_red   = ln_pend_red;
                            cur_green = ln_pend_green;
                            cur_blue  = v;
                            st        = ST_ALL;
                        end
                    end
                    CMD_H:    st = ST_HELP;
                    CMD_SHOW: st = ST_SHOW;
                    default:  st = ST_UNKNOWN;
                endcase
                fired      = 1'b1;
                rep.status = st;
                rep.red    = cur_red;
                rep.green  = cur_green;
                rep.blue   = cur_blue;
            end
            clear_line_state();
        end
        else if (!ln_started)
        begin
            if (!blank_char(c))
            begin
                clear_line_state();
                ln_started = 1'b1;
                ln_cmd     = command_of(c);
            end
        end
        else if (ln_cmd == CMD_C && ln_field < LAST_FIELD && c == CHAR_COMMA)
        begin
            // comma closes the first or second field of a C line
            if (!value_fits())
                ln_pend_ok = 1'b0;
            else if (ln_field == 2'd0)
                ln_pend_red = ln_mag[7:0];
            else
                ln_pend_green = ln_mag[7:0];
            ln_field = ln_field + 2'd1;
            ln_phase = PH_SKIP;
            ln_neg   = 1'b0;
            ln_mag   = 9'd0;
        end
        else
        begin
            if (ln_cmd == CMD_C && ln_field == 2'd0)
                ln_first_seen = 1'b1;
            take_number_char(c);
        end
    endfunction

    function void add_row(input string text, input row_kind_t kind,
                          input logic [3:0] st = ST_RED, input logic [7:0] r = 8'd0,
                          input logic [7:0] g = 8'd0, input logic [7:0] b = 8'd0);
        line_report_t rep;
        rep.status = st;
        rep.red    = r;
        rep.green  = g;
        rep.blue   = b;
        row_text.push_back(text);
        row_kind.push_back(kind);
        row_report.push_back(rep);
    endfunction

    function logic [7:0] random_blank();
        case ($urandom_range(0, 3))
            0:       return CHAR_SPACE;
            1:       return CHAR_TAB;
            2:       return CHAR_VT;
            default: return CHAR_FF;
        endcase
    endfunction

    function logic [7:0] junk_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CHAR_LF || c == CHAR_CR);
        return c;
    endfunction

    // Decimal field: blanks, sign, then a value biased toward the edges
    function void push_number();
        int    sel;
        int    v;
        string digits;
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 2)) line_buf.push_back(random_blank());
        sel = $urandom_range(0, 9);
        if (sel == 0)
            line_buf.push_back(CHAR_MINUS);
        else if (sel == 1)
            line_buf.push_back(CHAR_PLUS);
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return;
        if (sel == 1)
        begin
            // long enough to saturate
            line_buf.push_back(8'(CHAR_ZERO + $urandom_range(1, 9)));
            repeat ($urandom_range(5, 9))
                line_buf.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
            return;
        end
        case (sel)
            2:       v = $urandom_range(256, 999);
            3:       v = 255;
            4:       v = 0;
            default: v = $urandom_range(0, 255);
        endcase
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3)) line_buf.push_back(CHAR_ZERO);
        digits = $sformatf("%0d", v);
        for (int k = 0; k < digits.len(); k++)
            line_buf.push_back(digits[k]);
    endfunction

    // One random line: mostly well-formed commands, some noise and broken C lines
    function void build_random_line();
        int         sel;
        int         k;
        logic [7:0] cmd;
        line_buf.delete();
        sel = $urandom_range(0, 99);
        if (sel < 6)
            repeat ($urandom_range(1, 10)) line_buf.push_back(8'($urandom_range(0, 255)));
        else if (sel < 10)
            repeat ($urandom_range(0, 3)) line_buf.push_back(random_blank());
        else
        begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) line_buf.push_back(random_blank());
            k = $urandom_range(0, 19);
            if (k < 5)
                cmd = CHAR_UP_R;
            else if (k < 8)
                cmd = CHAR_UP_G;
            else if (k < 11)
                cmd = CHAR_UP_B;
            else if (k < 17)
                cmd = CHAR_UP_C;
            else if (k == 17)
                cmd = CHAR_UP_H;
            else if (k == 18)
                cmd = CHAR_QUERY;
            else
                cmd = junk_byte();
            if (k < 18 && $urandom_range(0, 1) == 1)
                cmd = cmd + CASE_OFFSET;
            line_buf.push_back(cmd);
            if (k >= 11 && k < 17)
            begin
                if ($urandom_range(0, 9) != 0)
                    push_number();
                line_buf.push_back(CHAR_COMMA);
                push_number();
                if ($urandom_range(0, 9) != 0)
                begin
                    line_buf.push_back(CHAR_COMMA);
                    push_number();
                end
            end
            else if (k < 11)
                push_number();
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 4)) line_buf.push_back(junk_byte());
        end
        case ($urandom_range(0, 3))
            0: line_buf.push_back(CHAR_LF);
            1: line_buf.push_back(CHAR_CR);
            2:
            begin
                line_buf.push_back(CHAR_CR);
                line_buf.push_back(CHAR_LF);
            end
            default:
            begin
                line_buf.push_back(CHAR_LF);
                line_buf.push_back(random_blank());
                line_buf.push_back(CHAR_CR);
            end
        endcase
    endfunction

    // Offer one byte, wait for its transfer, then update the mirror
    task automatic send_byte(input logic [7:0] c, input bit use_mirror);
        line_report_t rep;
        bit           fired;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= c;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
        parse_rx_byte(c, fired, rep);
        if (fired && use_mirror)
            expected_reports.push_back(rep);
    endtask

    // Stop offering and wait at falling edges until every report is in
    task automatic drain_reports();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_reports.size() != 0);
    endtask

    function void check_report();
        line_report_t want;
        if (expected_reports.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected report: status %0d rgb %0d %0d %0d",
                     $time, status, red, green, blue);
            return;
        end
        want = expected_reports.pop_front();
        if ({status, red, green, blue} !== want)
        begin
            errors++;
            $display("%0t: expected status %0d rgb %0d %0d %0d, actual status %0d rgb %0d %0d %0d",
                     $time, want.status, want.red, want.green, want.blue,
                     status, red, green, blue);
        end
    endfunction

    // Report side: check each transfer, stall in random bursts or one long hold
    initial
    begin
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                check_report();
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 9);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Byte side: reset, directed lines, random lines, final drain
    initial
    begin
        int  waited;
        bit  held;
        in_valid      <= 1'b0;
        rx_byte       <= 8'd0;
        rst_n         <= 1'b0;
        errors        = 0;
        bytes_sent    = 0;
        idle_on       = 1'b1;
        long_hold_req = 1'b0;
        held          = 1'b0;
        clear_line_state();
        cur_red   = 8'd0;
        cur_green = 8'd0;
        cur_blue  = 8'd0;

        add_row("?\n",                 ROW_TYPED, ST_SHOW,    8'd0,   8'd0, 8'd0);
        add_row("R255\n",              ROW_TYPED, ST_RED,     8'd255, 8'd0, 8'd0);
        add_row("g+256\r",             ROW_TYPED, ST_RANGE,   8'd255, 8'd0, 8'd0);
        add_row("b -0\n",              ROW_TYPED, ST_BLUE,    8'd255, 8'd0, 8'd0);
        add_row("B-1\n",               ROW_TYPED, ST_RANGE,   8'd255, 8'd0, 8'd0);
        add_row("\r\n \t\v\f\n",       ROW_QUIET);
        add_row(" \tc1,2,3\n",         ROW_TYPED, ST_ALL,     8'd1,   8'd2, 8'd3);
        add_row("C,2,3\r",             ROW_TYPED, ST_FORMAT,  8'd1,   8'd2, 8'd3);
        add_row("C1,2\n",              ROW_TYPED, ST_FORMAT,  8'd1,   8'd2, 8'd3);
        add_row("c9,300,4\n",          ROW_TYPED, ST_RANGE,   8'd1,   8'd2, 8'd3);
        add_row("C 007 ,+8x,-0,,5\n",  ROW_MODEL);
        add_row("h junk\n",            ROW_TYPED, ST_HELP,    8'd7,   8'd8, 8'd0);
        add_row("Zq\n",                ROW_TYPED, ST_UNKNOWN, 8'd7,   8'd8, 8'd0);
        add_row("r99999999\n",         ROW_TYPED, ST_RANGE,   8'd7,   8'd8, 8'd0);
        add_row("Gabc\n",              ROW_TYPED, ST_GREEN,   8'd7,   8'd0, 8'd0);
        add_row("R12,5\n",             ROW_MODEL);
        add_row("B7\r\n",              ROW_MODEL);
        add_row("R-\n",                ROW_MODEL);
        add_row("C-1,0,0\n",           ROW_MODEL);
        add_row("c 0,-0,255\n",        ROW_MODEL);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lines; typed rows owe their report at the line end
        foreach (row_text[i])
        begin
            for (int k = 0; k < row_text[i].len(); k++)
                send_byte(row_text[i][k], row_kind[i] == ROW_MODEL);
            if (row_kind[i] == ROW_TYPED)
                expected_reports.push_back(row_report[i]);
        end
        drain_reports();
        @(posedge clk);

        // random lines
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            if (!held && bytes_sent >= HOLD_AT)
            begin
                // hold the report side while bytes keep coming
                held = 1'b1;
                in_valid <= 1'b0;
                @(negedge clk);
                long_hold_req = 1'b1;
                @(posedge clk);
            end
            if (idle_on && bytes_sent >= CALM_AFTER)
            begin
                drain_reports();
                idle_on = 1'b0;
                @(posedge clk);
            end
            build_random_line();
            foreach (line_buf[k])
                send_byte(line_buf[k], 1'b1);
        end

        in_valid <= 1'b0;
        waited = 0;
        while (expected_reports.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (expected_reports.size() != 0)
        begin
            errors++;
            $display("%0t: %0d reports never arrived", $time, expected_reports.size());
        end
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ rgb_text_command_parser.f @@
+incdir+hw/rtl
hw/rtl/rgbtp_pkg.sv
hw/rtl/rgbtp_parser.sv
hw/rtl/rgb_text_command_parser.sv
tb/sv/testbench.sv
